// ===== rtl/sdq_pkg.sv =====
// ----------------------------------------------------------------------------
// sdq_pkg
// Shared types and constants for the sequence deque with reverse.
// ----------------------------------------------------------------------------
package sdq_pkg;

  localparam int DEF_CAPACITY = 16;
  localparam int DATA_W       = 32;
  localparam int OP_W         = 3;
  localparam int STATUS_W     = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ADD_BACK  = 3'd0,
    OP_ADD_FRONT = 3'd1,
    OP_REM_FRONT = 3'd2,
    OP_REM_BACK  = 3'd3,
    OP_REVERSE   = 3'd4,
    OP_LENGTH    = 3'd5,
    OP_READ_ALL  = 3'd6
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

endpackage

// ===== rtl/sdq_ram.sv =====
// ----------------------------------------------------------------------------
// sdq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sdq_ram #(
  parameter int WIDTH = sdq_pkg::DATA_W,
  parameter int DEPTH = sdq_pkg::DEF_CAPACITY
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/sequence_deque_with_reverse_unit.sv =====
// ----------------------------------------------------------------------------
// sequence_deque_with_reverse_unit
// Bounded deque of signed 32-bit values in a ring RAM with a direction flag.
// ----------------------------------------------------------------------------
// One request is taken at a time, once all results of the previous one are
// delivered. Add, reverse and length load their single result in the cycle
// of the request, so it shows in the next cycle. A remove reads the ring
// RAM; its result passes the registered RAM read port and then the output
// register. A read-out of N elements streams one element per cycle through
// the RAM read port while the output is not stalled. Reverse only flips the
// direction flag. No clearing pass follows reset.
module sequence_deque_with_reverse_unit #(
  parameter int CAPACITY = sdq_pkg::DEF_CAPACITY
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [sdq_pkg::OP_W-1:0]           in_op,
  input  logic signed [sdq_pkg::DATA_W-1:0]  in_item_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [sdq_pkg::DATA_W-1:0]  out_value,
  output logic [$clog2(CAPACITY+1)-1:0]      out_length,
  output logic [sdq_pkg::STATUS_W-1:0]       out_status,
  output logic                               out_last
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = CNT_W + 1;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_POP    = 3'b010,
    S_STREAM = 3'b100
  } fsm_t;

  fsm_t                        state_r, state_nxt;
  logic [IDX_W-1:0]            front_r, front_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic                        rev_r, rev_nxt;
  logic [CNT_W-1:0]            iss_r, iss_nxt;
  logic                        pend_r, pend_nxt;
  logic                        pend_last_r, pend_last_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [sdq_pkg::DATA_W-1:0]  out_value_r, out_value_nxt;
  logic [CNT_W-1:0]            out_length_r, out_length_nxt;
  logic [sdq_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic                        out_last_r, out_last_nxt;

  logic                        we, re;
  logic [IDX_W-1:0]            waddr, raddr;
  logic [sdq_pkg::DATA_W-1:0]  rdata;

  logic                        out_free, to_front, issue;
  logic                        ld, ld_last;
  logic [sdq_pkg::DATA_W-1:0]  ld_value;
  sdq_pkg::status_t            ld_status;

  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(a) + SUM_W'(b);
    if (sum >= SUM_W'(CAPACITY)) begin
      sum = sum - SUM_W'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

  sdq_ram #(
    .WIDTH(sdq_pkg::DATA_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk    (clk),
    .wr_en  (we),
    .wr_addr(waddr),
    .wr_data(in_item_value),
    .rd_en  (re),
    .rd_addr(raddr),
    .rd_data(rdata)
  );

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;

  always_comb begin
    state_nxt     = state_r;
    front_nxt     = front_r;
    count_nxt     = count_r;
    rev_nxt       = rev_r;
    iss_nxt       = iss_r;
    pend_nxt      = pend_r;
    pend_last_nxt = pend_last_r;
    we            = 1'b0;
    re            = 1'b0;
    waddr         = front_r;
    raddr         = front_r;
    to_front      = 1'b0;
    issue         = 1'b0;
    ld            = 1'b0;
    ld_value      = '0;
    ld_status     = sdq_pkg::ST_OK;
    ld_last       = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          case (in_op)
            sdq_pkg::OP_ADD_BACK, sdq_pkg::OP_ADD_FRONT: begin
              ld = 1'b1;
              if (count_r == CNT_W'(CAPACITY)) begin
                ld_status = sdq_pkg::ST_FULL;
              end else begin
                to_front = (in_op == sdq_pkg::OP_ADD_FRONT) ^ rev_r;
                we       = 1'b1;
                if (to_front) begin
                  front_nxt = (front_r == '0) ? IDX_W'(CAPACITY - 1)
                                              : front_r - 1'b1;
                  waddr     = front_nxt;
                end else begin
                  waddr = ring_add(front_r, count_r);
                end
                count_nxt = count_r + 1'b1;
              end
            end
            sdq_pkg::OP_REM_FRONT, sdq_pkg::OP_REM_BACK: begin
              if (count_r == '0) begin
                ld        = 1'b1;
                ld_status = sdq_pkg::ST_EMPTY;
              end else begin
                to_front = (in_op == sdq_pkg::OP_REM_FRONT) ^ rev_r;
                re       = 1'b1;
                if (to_front) begin
                  raddr     = front_r;
                  front_nxt = ring_add(front_r, CNT_W'(1));
                end else begin
                  raddr = ring_add(front_r, count_r - 1'b1);
                end
                count_nxt = count_r - 1'b1;
                state_nxt = S_POP;
              end
            end
            sdq_pkg::OP_REVERSE: begin
              rev_nxt = !rev_r;
              ld      = 1'b1;
            end
            sdq_pkg::OP_READ_ALL: begin
              if (count_r == '0) begin
                ld        = 1'b1;
                ld_status = sdq_pkg::ST_EMPTY;
              end else begin
                iss_nxt   = '0;
                pend_nxt  = 1'b0;
                state_nxt = S_STREAM;
              end
            end
            default: begin
              ld = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        if (out_free) begin
          ld        = 1'b1;
          ld_value  = rdata;
          state_nxt = S_IDLE;
        end
      end
      S_STREAM: begin
        if (pend_r && out_free) begin
          ld       = 1'b1;
          ld_value = rdata;
          ld_last  = pend_last_r;
        end
        issue = (!pend_r || out_free) && (iss_r != count_r);
        if (issue) begin
          re            = 1'b1;
          raddr         = ring_add(front_r, rev_r ? (count_r - 1'b1 - iss_r) : iss_r);
          iss_nxt       = iss_r + 1'b1;
          pend_last_nxt = (iss_r == count_r - 1'b1);
        end
        pend_nxt = issue || (pend_r && !out_free);
        if ((iss_r == count_r) && !pend_nxt) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt  = out_valid_r && !out_ready;
    out_value_nxt  = out_value_r;
    out_length_nxt = out_length_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    if (ld) begin
      out_valid_nxt  = 1'b1;
      out_value_nxt  = ld_value;
      out_length_nxt = count_nxt;
      out_status_nxt = ld_status;
      out_last_nxt   = ld_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      rev_r       <= 1'b0;
      iss_r       <= '0;
      pend_r      <= 1'b0;
      pend_last_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      rev_r       <= rev_nxt;
      iss_r       <= iss_nxt;
      pend_r      <= pend_nxt;
      pend_last_r <= pend_last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_length_r <= out_length_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_length = out_length_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

endmodule

// ===== rtl/sdq_checker.sv =====
// ----------------------------------------------------------------------------
// sdq_checker
// Port-level checks for the sequence deque, bound to the top level.
// ----------------------------------------------------------------------------
module sdq_checker #(
  parameter int CAPACITY = sdq_pkg::DEF_CAPACITY
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic [sdq_pkg::OP_W-1:0]           in_op,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [sdq_pkg::DATA_W-1:0]  out_value,
  input logic [$clog2(CAPACITY+1)-1:0]      out_length,
  input logic [sdq_pkg::STATUS_W-1:0]       out_status,
  input logic                               out_last
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == sdq_pkg::ST_FULL) |-> out_length == CNT_W'(CAPACITY))
    else $error("full status with length below capacity");

  a_empty_res: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == sdq_pkg::ST_EMPTY)
      |-> (out_length == '0) && out_last && (out_value == '0))
    else $error("empty status with bad payload");

  a_len_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_length <= CNT_W'(CAPACITY))
    else $error("length beyond capacity");

  a_reverse_res: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op == sdq_pkg::OP_REVERSE)
      |=> out_valid && out_last && (out_status == sdq_pkg::ST_OK) && (out_value == '0))
    else $error("reverse request without its result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_last))
    else $error("stalled result changed");

endmodule

bind sequence_deque_with_reverse_unit sdq_checker #(.CAPACITY(CAPACITY)) u_sdq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_op     (in_op),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_value (out_value),
  .out_length(out_length),
  .out_status(out_status),
  .out_last  (out_last)
);
